[src/biq_pkg.sv]
// biq_pkg: widths, codes, control structs and helper functions shared by the
// cascaded biquad filter, its interfaces and its multiply-accumulate unit.
// No dependencies.
package biq_pkg;

	// field widths
	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 32;
	localparam int SEC_FW   = 2;
	localparam int SLOT_W   = 3;

	// fixed point formats
	localparam int W_W       = 40;              // delay state, q24.16
	localparam int FRAC_W    = 16;
	localparam int COEF_FRAC = 28;              // coefficients, q4.28
	localparam int HALF_W    = 20;              // split point of the 40-bit operand
	localparam int OPND_W    = HALF_W + 1;      // one signed half
	localparam int MUL_W     = COEF_W + OPND_W; // partial product
	localparam int PROD_W    = 72;              // full product plus rounding
	localparam int TERM_W    = PROD_W - COEF_FRAC;
	localparam int ACC_W     = 46;

	localparam logic [PROD_W-1:0] RND_ADD = PROD_W'(1) << (COEF_FRAC - 1);

	// item codes
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// coefficient slots within a section
	localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;
	localparam int COEFS_PER_SEC = 5;

	// section schedule
	localparam int CYC_W      = 4;
	localparam logic [CYC_W-1:0] CYC_ISSUE_LAST = 4'd9;
	localparam logic [CYC_W-1:0] CYC_W0         = 4'd7;
	localparam logic [CYC_W-1:0] CYC_LAST       = 4'd13;

	// product terms in issue order
	typedef enum logic [2:0] {
		TERM_A1 = 3'd0,
		TERM_A2 = 3'd1,
		TERM_B1 = 3'd2,
		TERM_B2 = 3'd3,
		TERM_B0 = 3'd4
	} term_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic  vld;
		logic  hi;
		term_t term;
	} mac_ctl_t;

	typedef struct packed {
		logic  vld;
		term_t term;
	} mac_res_t;

	function automatic logic [SLOT_W-1:0] term_slot(input logic [2:0] t);
		logic [SLOT_W-1:0] s;
		case (t)
			TERM_A1: s = SLOT_A1;
			TERM_A2: s = SLOT_A2;
			TERM_B1: s = SLOT_B1;
			TERM_B2: s = SLOT_B2;
			default: s = SLOT_B0;
		endcase
		return s;
	endfunction

	function automatic logic signed [W_W-1:0] sat_w(input logic signed [ACC_W-1:0] v);
		logic signed [W_W-1:0] r;
		if (v[ACC_W-1:W_W-1] == '0 || v[ACC_W-1:W_W-1] == '1)
			r = v[W_W-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(W_W-1){1'b0}}};
		else
			r = {1'b0, {(W_W-1){1'b1}}};
		return r;
	endfunction

endpackage

[src/biq_if.sv]
// biq_if: valid/ready channels of the biquad filter, one for input items and
// one for result items. Depends on biq_pkg.
interface biq_in_if;
	import biq_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [SEC_FW-1:0]          coef_section;
	logic [SLOT_W-1:0]          coef_index;
	logic signed [COEF_W-1:0]   coef_value;

	modport source(output valid, op, sample_in, coef_section, coef_index, coef_value,
		input ready);
	modport sink(input valid, op, sample_in, coef_section, coef_index, coef_value,
		output ready);
endinterface

interface biq_out_if;
	import biq_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filtered_out;
	logic signed [SAMPLE_W-1:0] dry_out;

	modport source(output valid, filtered_out, dry_out, input ready);
	modport sink(input valid, filtered_out, dry_out, output ready);
endinterface

[src/biq_ram.sv]
// biq_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
module biq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[src/biq_mac.sv]
// biq_mac: shared multiplier of the biquad filter; forms one rounded
// coefficient*state product from two 32x21 partial products.
// Depends on biq_pkg.
module biq_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  biq_pkg::mac_ctl_t               ctl,
	input  logic signed [biq_pkg::COEF_W-1:0] coef,
	input  logic signed [biq_pkg::W_W-1:0]  opnd,
	output biq_pkg::mac_res_t               res,
	output logic signed [biq_pkg::TERM_W-1:0] term_val
);
	import biq_pkg::*;

	logic signed [OPND_W-1:0] half;
	logic signed [MUL_W-1:0]  mul_s2;
	logic                     vld_s2;
	logic                     hi_s2;
	term_t                    term_s2;
	logic signed [PROD_W-1:0] prod_s3;
	mac_res_t                 res_s3;

	// low half is unsigned, high half carries the sign
	always_comb begin
		if (ctl.hi)
			half = {opnd[W_W-1], opnd[W_W-1:HALF_W]};
		else
			half = {1'b0, opnd[HALF_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			res_s3 <= '0;
		end else begin
			vld_s2 <= ctl.vld;
			res_s3.vld <= vld_s2 & hi_s2;
			res_s3.term <= term_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			mul_s2  <= MUL_W'(coef) * MUL_W'(half);
			hi_s2   <= ctl.hi;
			term_s2 <= ctl.term;
		end
		if (vld_s2) begin
			if (hi_s2)
				prod_s3 <= prod_s3 + (PROD_W'(mul_s2) <<< HALF_W);
			else
				prod_s3 <= PROD_W'(mul_s2) + $signed(RND_ADD);
		end
	end

	assign res      = res_s3;
	assign term_val = prod_s3[PROD_W-1:COEF_FRAC];

endmodule

[src/cascaded_biquad_iir_filter.sv]
// cascaded_biquad_iir_filter: top level of the cascaded direct form II biquad
// filter. Depends on biq_pkg, biq_if, biq_ram and biq_mac.
//
// A filter item (op 0) runs through every section before the next item can
// be accepted; a coefficient write (op 1) leaves the sequencer idle and gives
// no result. The pace is set by the single 32x21 multiplier: every
// coefficient product is built from two partial products, so a section issues
// ten multiplies in a row, and the b0*w0 product waits for w0 to come out of
// the read, multiply, round and accumulate stages. The input is ready only
// while the sequencer is idle; a finished result sits in an output register,
// so the next item is taken while it waits. Coefficients are q4.28, the delay
// state is 40 bits with 16 fraction bits; each product is rounded half up, w0
// and y are saturated to 40 bits, and the last y is truncated toward zero to
// 24 bits. Every coefficient used must be written before the first filter
// item; the coefficient store is not cleared by reset.
module cascaded_biquad_iir_filter #(
	parameter int SECTIONS = 4
) (
	input logic clk,
	input logic arst_n,
	biq_in_if.sink   samp,
	biq_out_if.source res
);
	import biq_pkg::*;

	localparam int DEPTH  = SECTIONS * COEFS_PER_SEC;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int WADR_W = SEC_FW + SLOT_W + 2;

	state_t state_q, state_d;

	// sequencer
	logic [CYC_W-1:0]  cyc_q;
	logic [SEC_W-1:0]  sec_q;
	logic [ADDR_W-1:0] base_q;
	mac_ctl_t          iss_s1;

	// coefficient store ports
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [COEF_W-1:0]        ram_rdata;
	logic [WADR_W-1:0]        waddr_full;

	// datapath
	logic signed [W_W-1:0]    x_q;
	logic signed [W_W-1:0]    w0_q;
	logic signed [ACC_W-1:0]  w0acc_q;
	logic signed [ACC_W-1:0]  yacc_q;
	logic signed [W_W-1:0]    w1_q [SECTIONS];
	logic signed [W_W-1:0]    w2_q [SECTIONS];
	logic signed [W_W-1:0]    opnd;
	logic signed [SAMPLE_W-1:0] sample_q;
	mac_res_t                 mac_res;
	logic signed [TERM_W-1:0] term_val;

	// output register
	logic                       out_vld_q;
	logic signed [SAMPLE_W-1:0] filt_q;
	logic signed [SAMPLE_W-1:0] dry_q;
	logic signed [W_W-1:0]      y_rnd;

	logic acc_in;
	logic out_load;
	logic sec_end;

	assign samp.ready = (state_q == ST_IDLE);
	assign acc_in     = samp.valid & samp.ready;
	assign sec_end    = (state_q == ST_RUN) && (cyc_q == CYC_LAST);
	assign out_load   = (state_q == ST_OUT) && (!out_vld_q || res.ready);

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_in && samp.op == OP_FILTER) state_d = ST_RUN;
			ST_RUN:  if (sec_end && sec_q == SEC_W'(SECTIONS - 1)) state_d = ST_OUT;
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// coefficient writes: out-of-range slot or section is dropped
	assign waddr_full = WADR_W'(samp.coef_section) * WADR_W'(COEFS_PER_SEC)
		+ WADR_W'(samp.coef_index);
	assign ram_waddr  = waddr_full[ADDR_W-1:0];
	assign ram_we     = acc_in && samp.op == OP_COEF
		&& samp.coef_index < SLOT_W'(COEFS_PER_SEC)
		&& 32'(samp.coef_section) < SECTIONS;

	// step k of a section reads the coefficient of term k/2, half k%2
	assign ram_raddr = base_q + ADDR_W'(term_slot(cyc_q[CYC_W-1:1]));

	biq_ram #(
		.WIDTH(COEF_W),
		.DEPTH(DEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(samp.coef_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer counters and the delay line; the head of the delay line is
	// always the section being worked on, and it rotates once per section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q  <= '0;
			sec_q  <= '0;
			base_q <= '0;
			iss_s1 <= '0;
			for (int i = 0; i < SECTIONS; i++) begin
				w1_q[i] <= '0;
				w2_q[i] <= '0;
			end
		end else begin
			iss_s1.vld  <= (state_q == ST_RUN) && (cyc_q <= CYC_ISSUE_LAST);
			iss_s1.hi   <= cyc_q[0];
			iss_s1.term <= term_t'(cyc_q[CYC_W-1:1]);
			if (acc_in) begin
				cyc_q  <= '0;
				sec_q  <= '0;
				base_q <= '0;
			end else if (sec_end) begin
				cyc_q  <= '0;
				sec_q  <= sec_q + SEC_W'(1);
				base_q <= base_q + ADDR_W'(COEFS_PER_SEC);
				for (int i = 0; i < SECTIONS - 1; i++) begin
					w1_q[i] <= w1_q[i+1];
					w2_q[i] <= w2_q[i+1];
				end
				w1_q[SECTIONS-1] <= w0_q;
				w2_q[SECTIONS-1] <= w1_q[0];
			end else if (state_q == ST_RUN) begin
				cyc_q <= cyc_q + CYC_W'(1);
			end
		end
	end

	// operand for the issued step
	always_comb begin
		case (iss_s1.term)
			TERM_A1, TERM_B1: opnd = w1_q[0];
			TERM_A2, TERM_B2: opnd = w2_q[0];
			default:          opnd = w0_q;
		endcase
	end

	biq_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (iss_s1),
		.coef    ($signed(ram_rdata)),
		.opnd    (opnd),
		.res     (mac_res),
		.term_val(term_val)
	);

	// accumulators: feedback terms build w0, feed-forward terms build y
	always_ff @(posedge clk) begin
		if (acc_in && samp.op == OP_FILTER) begin
			sample_q <= samp.sample_in;
			x_q      <= {samp.sample_in, FRAC_W'(0)};
		end
		if (state_q == ST_RUN && cyc_q == '0) begin
			w0acc_q <= ACC_W'(x_q);
			yacc_q  <= '0;
		end else if (mac_res.vld) begin
			if (mac_res.term == TERM_A1 || mac_res.term == TERM_A2)
				w0acc_q <= w0acc_q - ACC_W'(term_val);
			else
				yacc_q <= yacc_q + ACC_W'(term_val);
		end
		if (state_q == ST_RUN && cyc_q == CYC_W0)
			w0_q <= sat_w(w0acc_q);
		if (sec_end)
			x_q <= sat_w(yacc_q);
	end

	// truncate toward zero: add 2^16-1 to negative values before the shift
	assign y_rnd = x_q + (x_q[W_W-1] ? W_W'({FRAC_W{1'b1}}) : W_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (res.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filt_q <= y_rnd[W_W-1:FRAC_W];
			dry_q  <= sample_q;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.filtered_out = filt_q;
	assign res.dry_out      = dry_q;

	// the multiplier finishes terms only while a sample is being filtered
	assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.vld |-> state_q == ST_RUN)
		else $error("product finished outside a filter pass");

	// no multiply may be in flight once the input is ready again
	assert property (@(posedge clk) disable iff (!arst_n)
		samp.ready |-> !iss_s1.vld)
		else $error("multiply still issued while idle");

	// a new result appears only from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

	// the section index moves only at the end of a section or on a new item
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cyc_q != CYC_LAST) |=> $stable(sec_q))
		else $error("section index moved mid-section");

	// coefficient store is written only while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE)
		else $error("coefficient write during a filter pass");

endmodule

[sim/testbench.sv]
// testbench: drives random and directed items through cascaded_biquad_iir_filter and
// checks every output against a bit-exact predictor of the fixed point biquad cascade
// depends on biq_pkg, biq_if and the filter rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import biq_pkg::*;

	localparam int SECTIONS       = 4;
	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int ITEMS_PER_RUN  = 220;   // per idling phase, three phases
	localparam int PRESSURE_HOLD  = 400;   // long receiver hold-off in the last phase
	localparam int DRAIN_CYCLES   = 120;   // quiet time at the end
	localparam int STALL_LIMIT    = 3000;  // cycles with no handshake before giving up
	localparam int MAX_REPORTS    = 10;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [W_W-1:0]      w40_t;
	typedef logic signed [79:0]         wide_t;   // holds any exact product plus sums

	// q4.28 landmarks used by the stimulus
	localparam coef_t COEF_ONE = coef_t'(1) <<< COEF_FRAC;
	localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam int    HALF_Q   = 134217728;   // 0.5
	localparam int    QUART_Q  = 67108864;    // 0.25
	localparam int    A2_SPAN  = 107374182;   // about 0.4

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// slot codes past a2, which the block must ignore
	localparam logic [SLOT_W-1:0] SLOT_UNUSED_FIRST = SLOT_A2 + 1'b1;
	localparam logic [SLOT_W-1:0] SLOT_UNUSED_LAST  = '1;

	// saturation bounds in the wide domain
	localparam wide_t STATE_HI = (wide_t'(1) <<< (W_W-1)) - 1;
	localparam wide_t STATE_LO = -(wide_t'(1) <<< (W_W-1));
	localparam wide_t OUT_HI   = (wide_t'(1) <<< (SAMPLE_W-1)) - 1;
	localparam wide_t OUT_LO   = -(wide_t'(1) <<< (SAMPLE_W-1));
	localparam wide_t ROUND_HALF = wide_t'(1) <<< (COEF_FRAC-1);

	typedef struct {
		logic                op;
		sample_t             sample;
		logic [SEC_FW-1:0]   section;
		logic [SLOT_W-1:0]   slot;
		coef_t               value;
	} filter_req_t;

	typedef struct packed {
		sample_t filtered;
		sample_t dry;
	} out_pair_t;

	// tracks coefficients and delay state, predicts each output and checks it
	class cascade_checker;
		coef_t     coef_store [SECTIONS*COEFS_PER_SEC];
		w40_t      delay_line [SECTIONS*2];
		out_pair_t pending_outputs [$];
		int mismatches, outputs_checked, filter_items, coef_writes, ignored_writes;
		int clipped_outputs;

		function new();
			foreach (coef_store[i]) coef_store[i] = '0;
			foreach (delay_line[i]) delay_line[i] = '0;
		endfunction

		// coefficient times state, rounded half up back to 16 fraction bits
		function wide_t product_term(coef_t c, w40_t w);
			wide_t cw, ww;
			cw = c;
			ww = w;
			return (cw * ww + ROUND_HALF) >>> COEF_FRAC;
		endfunction

		function w40_t sat_state(wide_t v);
			if (v > STATE_HI) return STATE_HI[W_W-1:0];
			if (v < STATE_LO) return STATE_LO[W_W-1:0];
			return v[W_W-1:0];
		endfunction

		// one sample through all sections, updating the delay pairs
		function out_pair_t run_cascade(sample_t sample);
			out_pair_t o;
			wide_t x, r;
			w40_t w0, w1, w2, ys;
			int s, base;
			x = sample;
			x = x <<< FRAC_W;
			ys = '0;
			for (s = 0; s < SECTIONS; s++) begin
				base = s * COEFS_PER_SEC;
				w1 = delay_line[2*s];
				w2 = delay_line[2*s+1];
				w0 = sat_state(x - product_term(coef_store[base+SLOT_A1], w1)
					- product_term(coef_store[base+SLOT_A2], w2));
				ys = sat_state(product_term(coef_store[base+SLOT_B0], w0)
					+ product_term(coef_store[base+SLOT_B1], w1)
					+ product_term(coef_store[base+SLOT_B2], w2));
				delay_line[2*s+1] = w1;
				delay_line[2*s]   = w0;
				x = ys;
			end
			// truncate toward zero, then clip to 24 bits
			x = ys;
			if (x >= 0)
				r = x >>> FRAC_W;
			else
				r = -((-x) >>> FRAC_W);
			if (r >= OUT_HI || r <= OUT_LO) clipped_outputs++;
			if (r > OUT_HI) r = OUT_HI;
			if (r < OUT_LO) r = OUT_LO;
			o.filtered = r[SAMPLE_W-1:0];
			o.dry      = sample;
			return o;
		endfunction

		function void take_item(logic op, sample_t sample, logic [SEC_FW-1:0] section,
			logic [SLOT_W-1:0] slot, coef_t value);
			if (op == OP_COEF) begin
				coef_writes++;
				if (slot < COEFS_PER_SEC && int'(section) < SECTIONS)
					coef_store[int'(section)*COEFS_PER_SEC + int'(slot)] = value;
				else
					ignored_writes++;
			end else begin
				filter_items++;
				pending_outputs.push_back(run_cascade(sample));
			end
		endfunction

		function void note_mismatch(string what, sample_t want, sample_t got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
		endfunction

		function void check_output(sample_t filtered, sample_t dry);
			out_pair_t want;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%t: output %0d/%0d with no item pending", $realtime, filtered, dry);
				return;
			end
			want = pending_outputs.pop_front();
			outputs_checked++;
			if (filtered !== want.filtered) note_mismatch("filtered_out", want.filtered, filtered);
			if (dry !== want.dry) note_mismatch("dry_out", want.dry, dry);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	biq_in_if  samp_ch ();
	biq_out_if res_ch ();

	cascade_checker sb = new();

	// idle percentages per side, and the remaining length of a forced hold-off
	int in_idle_pct  = 0;
	int out_idle_pct = 0;
	int hold_left    = 0;

	cascaded_biquad_iir_filter #(.SECTIONS(SECTIONS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samp   (samp_ch),
		.res    (res_ch)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// both channels are sampled at the edge, values from before the edge
	always @(posedge clk) begin
		if (samp_ch.valid === 1'b1 && samp_ch.ready === 1'b1)
			sb.take_item(samp_ch.op, samp_ch.sample_in, samp_ch.coef_section,
				samp_ch.coef_index, samp_ch.coef_value);
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			sb.check_output(res_ch.filtered_out, res_ch.dry_out);
	end

	// receiver: random backpressure, or a solid hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// watchdog: any stretch without a handshake on either side this long is a hang
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((samp_ch.valid === 1'b1 && samp_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d cycles with no handshake", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// uniform value in [-m, m]
	function automatic int spread(int m);
		return int'($urandom_range(2*m)) - m;
	endfunction

	// moderate and full-range levels, with the rails and tiny values mixed in
	function automatic sample_t random_sample();
		sample_t v;
		case ($urandom_range(9))
			0: v = SAMPLE_MAX;
			1: v = SAMPLE_MIN;
			2: v = sample_t'(spread(4));
			3, 4, 5: v = sample_t'(spread(4096));
			default: v = sample_t'($urandom());
		endcase
		return v;
	endfunction

	// stray coefficient values, many of them far outside a stable filter
	function automatic coef_t random_coef();
		coef_t v;
		case ($urandom_range(9))
			0: v = COEF_MAX;
			1: v = COEF_MIN;
			2: v = '0;
			3: v = COEF_ONE;
			4, 5: v = coef_t'($urandom());
			default: v = coef_t'(spread(HALF_Q << 1));
		endcase
		return v;
	endfunction

	// offer one item, with random idle cycles first; valid stays high after acceptance
	task automatic send_item(input filter_req_t it);
		while ($urandom_range(99) < in_idle_pct) begin
			samp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samp_ch.valid        <= 1'b1;
		samp_ch.op           <= it.op;
		samp_ch.sample_in    <= it.sample;
		samp_ch.coef_section <= it.section;
		samp_ch.coef_index   <= it.slot;
		samp_ch.coef_value   <= it.value;
		do @(posedge clk); while (samp_ch.ready !== 1'b1);
	endtask

	// write all coefficients: either a unity passthrough or a random stable set
	task automatic load_coefficients(input bit passthrough);
		filter_req_t it;
		int s, k;
		for (s = 0; s < SECTIONS; s++) begin
			for (k = 0; k < COEFS_PER_SEC; k++) begin
				it.op      = OP_COEF;
				it.sample  = random_sample();
				it.section = s[SEC_FW-1:0];
				it.slot    = k[SLOT_W-1:0];
				if (passthrough)
					it.value = (it.slot == SLOT_B0) ? COEF_ONE : '0;
				else if (it.slot == SLOT_A1)
					it.value = coef_t'(spread(HALF_Q));   // |a1| + |a2| < 1 keeps poles inside
				else if (it.slot == SLOT_A2)
					it.value = coef_t'(spread(A2_SPAN));
				else
					it.value = coef_t'(spread(QUART_Q));
				send_item(it);
			end
		end
	endtask

	// mostly samples through a stable cascade, with stray coefficient writes as noise
	task automatic run_random(input int count);
		filter_req_t it;
		int n;
		load_coefficients(1'b0);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(149) == 0) load_coefficients(1'b0);
			it.op      = ($urandom_range(99) < 8) ? OP_COEF : OP_FILTER;
			it.sample  = random_sample();
			it.section = SEC_FW'($urandom_range(3));
			it.slot    = SLOT_W'($urandom_range(7));
			it.value   = random_coef();
			send_item(it);
		end
	endtask

	initial begin
		filter_req_t it;
		arst_n               = 1'b0;
		samp_ch.valid        = 1'b0;
		samp_ch.op           = OP_FILTER;
		samp_ch.sample_in    = '0;
		samp_ch.coef_section = '0;
		samp_ch.coef_index   = '0;
		samp_ch.coef_value   = '0;
		res_ch.ready         = 1'b0;
		in_idle_pct          = 31;
		out_idle_pct         = 55;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unity cascade so the sample comes straight back
		load_coefficients(1'b1);

		// a write to a slot past a2 must not disturb the unity cascade
		it.op      = OP_COEF;
		it.sample  = '0;
		it.section = '0;
		it.slot    = SLOT_UNUSED_LAST;
		it.value   = COEF_MAX;
		send_item(it);

		// rails and minus one through the unity path
		it.op = OP_FILTER;
		it.sample = SAMPLE_MAX;
		send_item(it);
		it.sample = SAMPLE_MIN;
		send_item(it);
		it.sample = sample_t'(-1);
		send_item(it);

		// largest b0 in the last section: gain near eight drives the output into clipping
		it.op      = OP_COEF;
		it.section = SEC_FW'(SECTIONS - 1);
		it.slot    = SLOT_B0;
		it.value   = COEF_MAX;
		send_item(it);
		it.op = OP_FILTER;
		it.sample = SAMPLE_MAX;
		send_item(it);
		it.sample = SAMPLE_MIN;
		send_item(it);

		// write to the first unused slot as well
		it.op    = OP_COEF;
		it.slot  = SLOT_UNUSED_FIRST;
		it.value = COEF_MIN;
		send_item(it);

		// phase one: sender idles less than the receiver
		run_random(ITEMS_PER_RUN);

		// phase two: roles swapped
		in_idle_pct  = 55;
		out_idle_pct = 31;
		run_random(ITEMS_PER_RUN);

		// phase three: no idling, and a long receiver hold-off so the block backs up
		in_idle_pct  = 0;
		out_idle_pct = 0;
		hold_left <= PRESSURE_HOLD;
		run_random(ITEMS_PER_RUN);
		samp_ch.valid <= 1'b0;

		// let every pending output come out, then watch for strays
		while (sb.pending_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("filtered %0d samples and wrote %0d coefficients (%0d to unused slots)",
			sb.filter_items, sb.coef_writes, sb.ignored_writes);
		$display("checked %0d outputs, %0d at the clip rails, %0d mismatches",
			sb.outputs_checked, sb.clipped_outputs, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_outputs.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[cascaded_biquad_iir_filter.f]
src/biq_pkg.sv
src/biq_if.sv
src/biq_ram.sv
src/biq_mac.sv
src/cascaded_biquad_iir_filter.sv
sim/testbench.sv
